### rtl/core/mbha_pkg.sv
// Package: types, codes and constants for the marker byte heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package mbha_pkg;
   localparam int unsigned HEAP_BYTES_DEF = 1024;
   localparam logic [7:0] BEGIN_MARKER_RST = 8'd2;
   localparam logic [7:0] END_MARKER_RST = 8'd3;

   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE  = 2'd1;
   localparam logic [1:0] REQ_FILL  = 2'd2;
   localparam logic [1:0] REQ_COUNT = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_SPACE = 2'd1;
   localparam logic [1:0] ST_OVERRUN  = 2'd2;

   localparam logic CSR_BEGIN = 1'b0;
   localparam logic CSR_END   = 1'b1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_A_FIND_RD, S_A_FIND, S_A_CHK_RD, S_A_CHK, S_A_MARK,
      S_F_RD, S_F_CHK, S_L_RD, S_L_CHK, S_C_RD, S_C_CHK, S_DONE
   } state_type;

   // memory access request from the sequencer to the heap memory
   typedef struct packed {
      logic        rd;
      logic        wr;
      logic [15:0] addr;
      logic [7:0]  wdata;
   } mem_req_type;
endpackage
`default_nettype wire

### rtl/core/marker_byte_heap_allocator.sv
// Top level: marker byte heap allocator with configuration registers.
//  channel | ports                                  | direction
//  req     | req_valid/ready, type, offset, size, value | in
//  rsp     | rsp_valid/ready, status, data_offset, used_count | out
//  csr     | csr_we, csr_index, csr_wdata            | in
// Each heap byte is read in a read state and a check state through the single memory
// port; an out-of-range free needs no read, and a free, fill or count walk reads up to
// every heap byte; allocate rescans from each candidate so it may take several passes.
// After reset a clearing pass writes zero to every heap byte.
// A result waits in an output register; a new item enters when it is free or taken.
`timescale 1ns / 1ps
`default_nettype none
module marker_byte_heap_allocator #(
   parameter int unsigned HEAP_BYTES = mbha_pkg::HEAP_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [9:0]  req_offset,
   input  wire logic [9:0]  req_size,
   input  wire logic [7:0]  req_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [9:0]       rsp_data_offset,
   output logic [10:0]      rsp_used_count,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);
   import mbha_pkg::*;
   logic [7:0] begin_mk_ff, end_mk_ff;
   mem_req_type mreq;
   logic [7:0] rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         begin_mk_ff <= BEGIN_MARKER_RST;
         end_mk_ff <= END_MARKER_RST;
      end else if (csr_we) begin
         if (csr_index == CSR_BEGIN) begin_mk_ff <= csr_wdata;
         else end_mk_ff <= csr_wdata;
      end
   end

   mbha_seq #(.HEAP_BYTES(HEAP_BYTES)) u_seq (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_offset, .req_size,
      .req_value, .rsp_valid, .rsp_ready, .rsp_status, .rsp_data_offset,
      .rsp_used_count, .begin_mk(begin_mk_ff), .end_mk(end_mk_ff), .mreq, .rdata
   );

   mbha_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (.clock, .mreq, .rdata);

`ifndef SYNTHESIS
   a_no_rw: assert property (@(posedge clock) disable iff (reset) !(mreq.rd && mreq.wr))
      else $error("read and write in one cycle");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("bad status");
   a_off: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_data_offset == 10'd0)
      else $error("offset on failure");
`endif
endmodule
`default_nettype wire

### rtl/core/mbha_mem.sv
// Heap byte memory: one port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mbha_mem #(
   parameter int unsigned HEAP_BYTES = mbha_pkg::HEAP_BYTES_DEF,
   localparam int unsigned AW = $clog2(HEAP_BYTES)
) (
   input  wire logic                 clock,
   input  wire mbha_pkg::mem_req_type mreq,
   output logic [7:0]                rdata
);
   import mbha_pkg::*;
   logic [7:0] mem [HEAP_BYTES];
   always_ff @(posedge clock) begin
      if (mreq.wr) mem[mreq.addr[AW-1:0]] <= mreq.wdata;
      if (mreq.rd) rdata <= mem[mreq.addr[AW-1:0]];
   end
endmodule
`default_nettype wire

### rtl/core/mbha_seq.sv
// Request sequencer: walks the heap through the memory port.
`timescale 1ns / 1ps
`default_nettype none
module mbha_seq #(
   parameter int unsigned HEAP_BYTES = mbha_pkg::HEAP_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_type,
   input  wire logic [9:0]            req_offset,
   input  wire logic [9:0]            req_size,
   input  wire logic [7:0]            req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_status,
   output logic [9:0]                 rsp_data_offset,
   output logic [10:0]                rsp_used_count,
   input  wire logic [7:0]            begin_mk,
   input  wire logic [7:0]            end_mk,
   output mbha_pkg::mem_req_type      mreq,
   input  wire logic [7:0]            rdata
);
   import mbha_pkg::*;
   localparam logic [16:0] HB = 17'(HEAP_BYTES);

   state_type   state_ff, state_in;
   logic [16:0] pos_ff, pos_in;     // scan base
   logic [16:0] idx_ff, idx_in;     // current byte
   logic [16:0] lim_ff, lim_in;     // end of check / fill
   logic [1:0]  op_ff, op_in;
   logic [9:0]  size_ff, size_in;
   logic [7:0]  val_ff, val_in;
   logic        cnt_on_ff, cnt_on_in;
   logic        mark_ff, mark_in;   // end marker seen, read of next byte pending
   logic [10:0] cnt_ff, cnt_in;
   logic [1:0]  st_ff, st_in;
   logic [9:0]  doff_ff, doff_in;
   logic [10:0] used_ff, used_in;
   logic        rv_ff, rv_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         rv_ff <= rv_in;
      end
      pos_ff <= pos_in; lim_ff <= lim_in; op_ff <= op_in; size_ff <= size_in;
      val_ff <= val_in; cnt_on_ff <= cnt_on_in; mark_ff <= mark_in;
      cnt_ff <= cnt_in; st_ff <= st_in; doff_ff <= doff_in; used_ff <= used_in;
   end

   always_comb begin
      state_in = state_ff; pos_in = pos_ff; idx_in = idx_ff; lim_in = lim_ff;
      op_in = op_ff; size_in = size_ff; val_in = val_ff; cnt_on_in = cnt_on_ff;
      mark_in = mark_ff; cnt_in = cnt_ff; st_in = st_ff; doff_in = doff_ff;
      used_in = used_ff; rv_in = rv_ff;
      mreq = '0;
      req_ready = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            mreq.wr = 1'b1; mreq.addr = idx_ff[15:0];
            idx_in = idx_ff + 17'd1;
            if (idx_ff == HB - 17'd1) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = !rv_ff || rsp_ready;
            if (req_valid && req_ready) begin
               op_in = req_type; size_in = req_size; val_in = req_value;
               st_in = ST_OK; doff_in = '0; used_in = '0;
               idx_in = 17'(req_offset);
               case (req_type)
                  REQ_ALLOC: begin
                     mreq.wr = 1'b1; mreq.addr = '0; mreq.wdata = end_mk;
                     idx_in = '0; mark_in = 1'b0; state_in = S_A_FIND_RD;
                  end
                  REQ_FREE: begin
                     if (17'(req_offset) >= HB) begin
                        st_in = ST_NO_SPACE; state_in = S_DONE;
                     end else begin
                        if (req_offset != 10'd0) begin
                           mreq.wr = 1'b1; mreq.addr = 16'(req_offset - 10'd1);
                        end
                        state_in = S_F_RD;
                     end
                  end
                  REQ_FILL: begin
                     lim_in = 17'(req_offset) + 17'(req_size);
                     state_in = S_L_RD;
                  end
                  default: begin
                     idx_in = 17'd1; cnt_in = 11'd1; cnt_on_in = 1'b0;
                     state_in = S_C_RD;
                  end
               endcase
            end
         end
         S_A_FIND_RD: begin
            if (idx_ff >= HB) begin
               st_in = ST_NO_SPACE; state_in = S_DONE;
            end else begin
               mreq.rd = 1'b1; mreq.addr = idx_ff[15:0]; state_in = S_A_FIND;
            end
         end
         S_A_FIND: begin
            // mark_ff: an end marker was found at pos_ff and rdata holds the byte after it
            if (mark_ff) begin
               mark_in = 1'b0;
               if (rdata == begin_mk) begin
                  idx_in = pos_ff + 17'd2; state_in = S_A_FIND_RD;
               end else if (pos_ff + 17'(size_ff) + 17'd2 >= HB) begin
                  st_in = ST_NO_SPACE; state_in = S_DONE;
               end else begin
                  idx_in = pos_ff + 17'd2;
                  lim_in = pos_ff + 17'(size_ff) + 17'd2;
                  state_in = S_A_CHK_RD;
               end
            end else if (rdata == end_mk) begin
               pos_in = idx_ff;
               if (idx_ff + 17'd1 >= HB) begin
                  st_in = ST_NO_SPACE; state_in = S_DONE;
               end else begin
                  mark_in = 1'b1;
                  mreq.rd = 1'b1; mreq.addr = 16'(idx_ff + 17'd1);
               end
            end else begin
               idx_in = idx_ff + 17'd1; state_in = S_A_FIND_RD;
            end
         end
         S_A_CHK_RD: begin
            mreq.rd = 1'b1; mreq.addr = idx_ff[15:0]; state_in = S_A_CHK;
         end
         S_A_CHK: begin
            if (rdata == begin_mk) begin
               idx_in = pos_ff + 17'd1; state_in = S_A_FIND_RD;
            end else if (idx_ff == lim_ff) begin
               mreq.wr = 1'b1; mreq.addr = 16'(pos_ff + 17'd1); mreq.wdata = begin_mk;
               doff_in = 10'(pos_ff + 17'd2);
               state_in = S_A_MARK;
            end else begin
               idx_in = idx_ff + 17'd1; state_in = S_A_CHK_RD;
            end
         end
         S_A_MARK: begin
            mreq.wr = 1'b1; mreq.addr = lim_ff[15:0]; mreq.wdata = end_mk;
            state_in = S_DONE;
         end
         S_F_RD: begin
            if (idx_ff >= HB) begin
               st_in = ST_NO_SPACE; state_in = S_DONE;
            end else begin
               mreq.rd = 1'b1; mreq.addr = idx_ff[15:0]; state_in = S_F_CHK;
            end
         end
         S_F_CHK: begin
            mreq.wr = 1'b1; mreq.addr = idx_ff[15:0];
            idx_in = idx_ff + 17'd1;
            state_in = (rdata == end_mk) ? S_DONE : S_F_RD;
         end
         S_L_RD: begin
            if (idx_ff == lim_ff) state_in = S_DONE;
            else if (idx_ff >= HB) begin
               st_in = ST_NO_SPACE; state_in = S_DONE;
            end else begin
               mreq.rd = 1'b1; mreq.addr = idx_ff[15:0]; state_in = S_L_CHK;
            end
         end
         S_L_CHK: begin
            if (rdata == end_mk) begin
               st_in = ST_OVERRUN; state_in = S_DONE;
            end else begin
               mreq.wr = 1'b1; mreq.addr = idx_ff[15:0]; mreq.wdata = val_ff;
               idx_in = idx_ff + 17'd1; state_in = S_L_RD;
            end
         end
         S_C_RD: begin
            if (idx_ff >= HB) begin
               used_in = cnt_ff; state_in = S_DONE;
            end else begin
               mreq.rd = 1'b1; mreq.addr = idx_ff[15:0]; state_in = S_C_CHK;
            end
         end
         S_C_CHK: begin
            // saturating add of up to two
            logic [11:0] sum;
            sum = 12'(cnt_ff) + 12'(cnt_on_ff) + 12'(rdata == begin_mk);
            cnt_in = (sum > 12'd2047) ? 11'd2047 : sum[10:0];
            if (rdata == begin_mk) cnt_on_in = 1'b1;
            else if (rdata == end_mk) cnt_on_in = 1'b0;
            idx_in = idx_ff + 17'd1; state_in = S_C_RD;
         end
         S_DONE: begin
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_data_offset = doff_ff;
   assign rsp_used_count = used_ff;
endmodule
`default_nettype wire

### verif/testbench.sv
// Testbench for the marker byte heap allocator: queued requests, heap predictor, response checks.
`timescale 1ns / 1ps
module testbench;
   import mbha_pkg::*;

   localparam int HEAP_N = 1024;
   localparam int STALL_LIMIT = 12000000;

   typedef struct {
      logic [1:0] kind;
      logic [9:0] off;
      logic [9:0] size;
      logic [7:0] val;
   } heap_req_t;

   typedef struct {
      logic [1:0]  status;
      logic [9:0]  data_offset;
      logic [10:0] used_count;
   } heap_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = REQ_COUNT;
   logic [9:0]  req_offset = '0;
   logic [9:0]  req_size = '0;
   logic [7:0]  req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [9:0]  rsp_data_offset;
   logic [10:0] rsp_used_count;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_BEGIN;
   logic [7:0]  csr_wdata = '0;

   heap_req_t pending_reqs[$];
   heap_rsp_t expected_rsps[$];
   int        live_offsets[$];
   logic [7:0] heap_shadow[HEAP_N];
   logic [7:0] shadow_begin;
   logic [7:0] shadow_end;
   int        errors = 0;
   int        cyc = 0;
   int        stall_cycles = 0;

   marker_byte_heap_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_offset(req_offset), .req_size(req_size), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_data_offset(rsp_data_offset), .rsp_used_count(rsp_used_count),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // no idling in this window
   function automatic bit quiet_window();
      return cyc >= 20000 && cyc < 70000;
   endfunction

   function automatic logic [1:0] heap_alloc(int sz, output int doff);
      int pos;
      bit clean;
      doff = 0;
      pos = 0;
      heap_shadow[0] = shadow_end;
      while (1) begin
         while (1) begin
            if (pos >= HEAP_N) return ST_NO_SPACE;
            if (heap_shadow[pos] == shadow_end) begin
               if (pos + 1 < HEAP_N && heap_shadow[pos + 1] == shadow_begin) begin
                  pos += 2;
                  continue;
               end
               break;
            end
            pos++;
         end
         if (pos + sz + 2 >= HEAP_N) return ST_NO_SPACE;
         clean = 1'b1;
         for (int k = 2; k <= sz + 2; k++) begin
            if (heap_shadow[pos + k] == shadow_begin) begin
               clean = 1'b0;
               break;
            end
         end
         if (clean) begin
            heap_shadow[pos + 1] = shadow_begin;
            heap_shadow[pos + sz + 2] = shadow_end;
            doff = pos + 2;
            return ST_OK;
         end
         pos++;
      end
   endfunction

   function automatic logic [1:0] heap_free(int off);
      bit last;
      if (off > 0) heap_shadow[off - 1] = 8'd0;
      for (int i = off; i < HEAP_N; i++) begin
         last = heap_shadow[i] == shadow_end;
         heap_shadow[i] = 8'd0;
         if (last) return ST_OK;
      end
      return ST_NO_SPACE;
   endfunction

   function automatic logic [1:0] heap_fill(int off, int n, logic [7:0] v);
      for (int i = 0; i < n; i++) begin
         if (off + i >= HEAP_N) return ST_NO_SPACE;
         if (heap_shadow[off + i] == shadow_end) return ST_OVERRUN;
         heap_shadow[off + i] = v;
      end
      return ST_OK;
   endfunction

   function automatic int heap_used();
      int cnt;
      bit on;
      cnt = 1;
      on = 1'b0;
      for (int i = 1; i < HEAP_N; i++) begin
         if (on) cnt++;
         if (heap_shadow[i] == shadow_begin) begin
            cnt++;
            on = 1'b1;
         end else if (heap_shadow[i] == shadow_end) begin
            on = 1'b0;
         end
      end
      return cnt > 2047 ? 2047 : cnt;
   endfunction

   // queue a request and the response the heap shadow predicts for it
   task automatic issue_request(logic [1:0] kind, int off, int size, logic [7:0] val);
      heap_req_t r;
      heap_rsp_t e;
      int doff;
      r.kind = kind;
      r.off = off[9:0];
      r.size = size[9:0];
      r.val = val;
      e.status = ST_OK;
      e.data_offset = '0;
      e.used_count = '0;
      case (kind)
         REQ_ALLOC: begin
            e.status = heap_alloc(r.size, doff);
            e.data_offset = doff[9:0];
            if (e.status == ST_OK) live_offsets.push_back(doff);
         end
         REQ_FREE: e.status = heap_free(r.off);
         REQ_FILL: e.status = heap_fill(r.off, r.size, val);
         default: e.used_count = heap_used();
      endcase
      pending_reqs.push_back(r);
      expected_rsps.push_back(e);
   endtask

   task automatic write_markers(logic [7:0] b, logic [7:0] e);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_BEGIN;
      csr_wdata <= b;
      @(posedge clock);
      csr_index <= CSR_END;
      csr_wdata <= e;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_begin = b;
      shadow_end = e;
   endtask

   task automatic wait_drained();
      while (expected_rsps.size() != 0 || pending_reqs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_requests(int n);
      int r;
      int idx;
      int sz;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         sz = ($urandom_range(99) < 4) ? $urandom_range(1023) : $urandom_range(24);
         if (r < 35) begin
            issue_request(REQ_ALLOC, $urandom_range(1023), sz, $urandom_range(255));
         end else if (r < 55 && live_offsets.size() > 0) begin
            idx = $urandom_range(live_offsets.size() - 1);
            issue_request(REQ_FILL, live_offsets[idx], sz, $urandom_range(255));
         end else if (r < 75 && live_offsets.size() > 0) begin
            idx = $urandom_range(live_offsets.size() - 1);
            issue_request(REQ_FREE, live_offsets[idx], $urandom_range(1023),
                          $urandom_range(255));
            live_offsets.delete(idx);
         end else if (r < 85) begin
            issue_request(REQ_COUNT, $urandom_range(1023), $urandom_range(1023),
                          $urandom_range(255));
         end else begin
            issue_request($urandom_range(3), $urandom_range(1023), sz, $urandom_range(255));
         end
      end
   endtask

   // driver: valid holds until the transfer, idles at random otherwise
   always @(posedge clock) begin
      cyc <= cyc + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_ready)) begin
         if (req_valid) pending_reqs.pop_front();
         if (pending_reqs.size() > 0 && (quiet_window() || $urandom_range(99) >= 22)) begin
            req_valid <= 1'b1;
            req_type <= pending_reqs[0].kind;
            req_offset <= pending_reqs[0].off;
            req_size <= pending_reqs[0].size;
            req_value <= pending_reqs[0].val;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and response backpressure
   always @(posedge clock) begin
      heap_rsp_t e;
      rsp_ready <= reset ? 1'b0 : (quiet_window() || $urandom_range(99) >= 22);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response status=%0d data_offset=%0d used_count=%0d",
                     $time, rsp_status, rsp_data_offset, rsp_used_count);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_data_offset !== e.data_offset) begin
               $display("%0t: data_offset expected %0d actual %0d", $time,
                        e.data_offset, rsp_data_offset);
               errors++;
            end
            if (rsp_used_count !== e.used_count) begin
               $display("%0t: used_count expected %0d actual %0d", $time,
                        e.used_count, rsp_used_count);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int a;
      for (int i = 0; i < HEAP_N; i++) heap_shadow[i] = 8'd0;
      shadow_begin = BEGIN_MARKER_RST;
      shadow_end = END_MARKER_RST;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset markers
      issue_request(REQ_COUNT, 0, 0, 8'h00);
      issue_request(REQ_ALLOC, 0, 0, 8'h00);
      issue_request(REQ_ALLOC, 1023, 1023, 8'hff);
      issue_request(REQ_ALLOC, 0, 5, 8'h00);
      a = live_offsets.size() > 0 ? live_offsets[$] : 4;
      issue_request(REQ_FILL, a, 5, 8'hff);
      issue_request(REQ_FILL, a, 9, 8'h5a);       // runs into end marker
      issue_request(REQ_FILL, a, 0, 8'h11);       // zero length
      issue_request(REQ_ALLOC, 0, 1, 8'h00);
      issue_request(REQ_COUNT, 1023, 1023, 8'hff);
      issue_request(REQ_FILL, 1020, 1023, 8'h00); // past heap end
      issue_request(REQ_FILL, 1023, 1, 8'h00);
      issue_request(REQ_FREE, a, 0, 8'h00);
      issue_request(REQ_FREE, 0, 0, 8'h00);       // no byte before offset
      issue_request(REQ_FREE, 1000, 0, 8'h00);    // no end marker before heap end
      issue_request(REQ_ALLOC, 0, 990, 8'h00);
      issue_request(REQ_ALLOC, 0, 1019, 8'h00);
      issue_request(REQ_COUNT, 0, 0, 8'h00);
      issue_request(REQ_FREE, 1023, 1023, 8'hff);
      issue_request(REQ_COUNT, 0, 0, 8'h00);
      random_requests(40);
      wait_drained();

      write_markers(8'h00, 8'hff);
      issue_request(REQ_ALLOC, 0, 3, 8'h00);
      issue_request(REQ_COUNT, 0, 0, 8'h00);
      random_requests(40);
      wait_drained();

      write_markers(8'hff, 8'h00);
      random_requests(40);
      wait_drained();

      // equal markers
      write_markers(8'h07, 8'h07);
      random_requests(35);
      wait_drained();

      write_markers(8'haa, 8'h55);
      random_requests(45);
      wait_drained();

      write_markers($urandom_range(255), $urandom_range(255));
      random_requests(30);
      wait_drained();

      write_markers(BEGIN_MARKER_RST, END_MARKER_RST);
      random_requests(45);
      wait_drained();

      repeat (50) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

### files.f
rtl/core/mbha_pkg.sv
rtl/core/mbha_mem.sv
rtl/core/mbha_seq.sv
rtl/core/marker_byte_heap_allocator.sv
verif/testbench.sv
